/* sv/ghde_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none

package ghde_pkg;

    // Offset width: difference of two 32-bit signed coordinates
    localparam int DW = 33;
    // CORDIC datapath width: covers pre-rotation and gain growth
    localparam int CW = 36;
    // Binary angle width
    localparam int AW = 16;
    // Distance width, Q17.16
    localparam int DIST_W = 33;
    // Tolerance register width
    localparam int TOL_W = 32;
    // Square of one offset magnitude, and sum of two squares
    localparam int SQ_W = 65;
    localparam int RAD_W = 66;
    // Square root remainder width and step count (two radicand bits per step)
    localparam int REM_W = 36;
    localparam int SQRT_STEPS = 33;
    // Latency of the distance unit: abs, partial products, squares, sum, steps
    localparam int SQRT_LAT = 4 + SQRT_STEPS;

    localparam logic [DIST_W-1:0] DIST_LIMIT = 33'd6074001000;
    localparam logic [TOL_W-1:0] TOL_RESET = 32'd6554;

    // atan(2^-i) as a 32-bit binary angle (2^32 is one full turn)
    localparam logic [31:0] ATAN_TURNS [32] = '{
        32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4,
        32'h028B0D43, 32'h0145D7E1, 32'h00A2F61E, 32'h00517C55,
        32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
        32'h00028BE6, 32'h000145F3, 32'h0000A2FA, 32'h0000517D,
        32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
        32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051,
        32'h00000029, 32'h00000014, 32'h0000000A, 32'h00000005,
        32'h00000003, 32'h00000001, 32'h00000001, 32'h00000000
    };

    // Goal offset and yaw, shared by the bearing and distance units
    typedef struct packed {
        logic signed [DW-1:0] dx;
        logic signed [DW-1:0] dy;
        logic [AW-1:0]        yaw;
    } ghde_delta_t;

endpackage

`default_nettype wire

/* sv/ghde_cordic.sv */
`timescale 1ns / 1ps
`default_nettype none

// Vectoring CORDIC: bearing of (dx, dy) minus yaw, wrapped.
// Registered pre-rotation, micro-rotation stages and yaw-subtracting output.
module ghde_cordic #(
    parameter int STAGES = 16
) (
    input  wire logic                      clk,
    input  wire logic                      en,
    input  wire ghde_pkg::ghde_delta_t     delta,
    output logic [ghde_pkg::AW-1:0]        heading_error
);
    import ghde_pkg::*;

    logic signed [CW-1:0] x_reg    [STAGES+1];
    logic signed [CW-1:0] y_reg    [STAGES+1];
    logic [31:0]          z_reg    [STAGES+1];
    logic [AW-1:0]        yaw_reg  [STAGES+1];
    logic                 zero_reg [STAGES+1];
    logic [AW-1:0]        err_reg;

    logic signed [CW-1:0] dx_ext;
    logic signed [CW-1:0] dy_ext;
    logic [31:0]          z_rnd;
    logic [AW-1:0]        b16;

    assign dx_ext = {{(CW-DW){delta.dx[DW-1]}}, delta.dx};
    assign dy_ext = {{(CW-DW){delta.dy[DW-1]}}, delta.dy};

    // Pre-rotation by pi into the right half plane
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            if (delta.dx[DW-1])
            begin
                x_reg[0] <= -dx_ext;
                y_reg[0] <= -dy_ext;
                z_reg[0] <= 32'h80000000;
            end
            else
            begin
                x_reg[0] <= dx_ext;
                y_reg[0] <= dy_ext;
                z_reg[0] <= 32'h00000000;
            end
            yaw_reg[0]  <= delta.yaw;
            zero_reg[0] <= (delta.dx == '0) && (delta.dy == '0);
        end
    end

    // Micro-rotations, one per stage
    for (genvar i = 0; i < STAGES; i++)
    begin : g_stage
        logic signed [CW-1:0] xs;
        logic signed [CW-1:0] ys;

        assign xs = x_reg[i] >>> i;
        assign ys = y_reg[i] >>> i;

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                if (!y_reg[i][CW-1])
                begin
                    x_reg[i+1] <= x_reg[i] + ys;
                    y_reg[i+1] <= y_reg[i] - xs;
                    z_reg[i+1] <= z_reg[i] + ATAN_TURNS[i];
                end
                else
                begin
                    x_reg[i+1] <= x_reg[i] - ys;
                    y_reg[i+1] <= y_reg[i] + xs;
                    z_reg[i+1] <= z_reg[i] - ATAN_TURNS[i];
                end
                yaw_reg[i+1]  <= yaw_reg[i];
                zero_reg[i+1] <= zero_reg[i];
            end
        end
    end

    // Round to 16-bit angle, subtract yaw; goal at robot gives bearing 0
    assign z_rnd = z_reg[STAGES] + 32'h00008000;
    assign b16   = zero_reg[STAGES] ? '0 : z_rnd[31:16];

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            err_reg <= b16 - yaw_reg[STAGES];
        end
    end

    assign heading_error = err_reg;

endmodule

`default_nettype wire

/* sv/ghde_isqrt.sv */
`timescale 1ns / 1ps
`default_nettype none

// Exact floor(sqrt(dx^2 + dy^2)), pipelined.
module ghde_isqrt (
    input  wire logic                      clk,
    input  wire logic                      en,
    input  wire ghde_pkg::ghde_delta_t     delta,
    output logic [ghde_pkg::DIST_W-1:0]    root
);
    import ghde_pkg::*;

    logic [DW-1:0]    ax_reg;
    logic [DW-1:0]    ay_reg;
    logic [33:0]      xhh_reg;
    logic [32:0]      xhl_reg;
    logic [31:0]      xll_reg;
    logic [33:0]      yhh_reg;
    logic [32:0]      yhl_reg;
    logic [31:0]      yll_reg;
    logic [SQ_W-1:0]  sx_reg;
    logic [SQ_W-1:0]  sy_reg;

    logic [RAD_W-1:0]  rad_reg  [SQRT_STEPS];
    logic [REM_W-1:0]  rem_reg  [SQRT_STEPS];
    logic [DIST_W-1:0] root_reg [SQRT_STEPS+1];

    // Magnitudes
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            ax_reg <= delta.dx[DW-1] ? (~delta.dx + 33'd1) : delta.dx;
            ay_reg <= delta.dy[DW-1] ? (~delta.dy + 33'd1) : delta.dy;
        end
    end

    // Partial products, 17x17 and smaller
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            xhh_reg <= 34'(ax_reg[32:16]) * 34'(ax_reg[32:16]);
            xhl_reg <= 33'(ax_reg[32:16]) * 33'(ax_reg[15:0]);
            xll_reg <= 32'(ax_reg[15:0]) * 32'(ax_reg[15:0]);
            yhh_reg <= 34'(ay_reg[32:16]) * 34'(ay_reg[32:16]);
            yhl_reg <= 33'(ay_reg[32:16]) * 33'(ay_reg[15:0]);
            yll_reg <= 32'(ay_reg[15:0]) * 32'(ay_reg[15:0]);
        end
    end

    // Squares
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            sx_reg <= (SQ_W'(xhh_reg) << 32) + (SQ_W'(xhl_reg) << 17) + SQ_W'(xll_reg);
            sy_reg <= (SQ_W'(yhh_reg) << 32) + (SQ_W'(yhl_reg) << 17) + SQ_W'(yll_reg);
        end
    end

    // Sum of squares seeds the root recurrence
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            rad_reg[0]  <= RAD_W'(sx_reg) + RAD_W'(sy_reg);
            rem_reg[0]  <= '0;
            root_reg[0] <= '0;
        end
    end

    // One root bit per stage, two radicand bits consumed
    for (genvar k = 0; k < SQRT_STEPS; k++)
    begin : g_step
        logic [REM_W-1:0] rem_sh;
        logic [REM_W-1:0] trial;
        logic             take;

        assign rem_sh = {rem_reg[k][REM_W-3:0], rad_reg[k][RAD_W-1 -: 2]};
        assign trial  = REM_W'({root_reg[k], 2'b01});
        assign take   = (rem_sh >= trial);

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                root_reg[k+1] <= {root_reg[k][DIST_W-2:0], take};
            end
        end

        if (k < SQRT_STEPS - 1)
        begin : g_carry
            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    rem_reg[k+1] <= take ? (rem_sh - trial) : rem_sh;
                    rad_reg[k+1] <= {rad_reg[k][RAD_W-3:0], 2'b00};
                end
            end
        end
    end

    assign root = root_reg[SQRT_STEPS];

endmodule

`default_nettype wire

/* sv/goal_heading_distance_error.sv */
`timescale 1ns / 1ps
`default_nettype none

// Go-to-goal heading and distance error. Each input transfer carries a goal
// point and the robot pose; each yields one output transfer with the wrapped
// heading error (bearing by vectoring CORDIC minus yaw, 32768 = pi), the exact
// floor Euclidean distance in Q17.16 and an arrived flag (distance at or below
// the tolerance register). Fully pipelined: it accepts one transfer every cycle
// unless the output stalls, with depth set by the 33-step square-root pipeline
// plus offset, magnitude, product, square, sum and output stages. A stall on
// the output freezes the whole pipeline, so s_axis_tready follows m_axis_tready
// whenever a result is waiting. The tolerance is sampled at the output stage.
module goal_heading_distance_error #(
    parameter int CORDIC_STAGES = 16
) (
    input  wire logic         clk,
    input  wire logic         rst_n,

    input  wire logic         s_axis_tvalid,
    output logic              s_axis_tready,
    // goal_x[31:0], goal_y[63:32], robot_x[95:64], robot_y[127:96], robot_yaw[143:128]
    input  wire logic [143:0] s_axis_tdata,

    output logic              m_axis_tvalid,
    input  wire logic         m_axis_tready,
    // heading_error[15:0], goal_distance[48:16], arrived[49], zero[55:50]
    output logic [55:0]       m_axis_tdata,

    input  wire logic         cfg_we,
    input  wire logic [31:0]  cfg_wdata
);
    import ghde_pkg::*;

    localparam int PIPE_DEPTH = SQRT_LAT + 2;
    localparam int HD = SQRT_LAT - (CORDIC_STAGES + 2);

    logic                    en;
    logic [PIPE_DEPTH-1:0]   valid_reg;
    logic [TOL_W-1:0]        tol_reg;
    ghde_delta_t             delta_reg;
    ghde_delta_t             delta_next;

    logic [AW-1:0]           cordic_err;
    logic [DIST_W-1:0]       root;
    logic [AW-1:0]           hd_reg [HD];

    logic [AW-1:0]           err_reg;
    logic [DIST_W-1:0]       dist_reg;
    logic                    arrived_reg;
    logic [DIST_W-1:0]       dist_next;

    // Whole pipeline advances unless a result is held
    assign en            = !valid_reg[PIPE_DEPTH-1] || m_axis_tready;
    assign s_axis_tready = en;

    // Valid bits travel alongside the data stages
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else if (en)
        begin
            valid_reg <= {valid_reg[PIPE_DEPTH-2:0], s_axis_tvalid};
        end
    end

    // Tolerance register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tol_reg <= TOL_RESET;
        end
        else if (cfg_we)
        begin
            tol_reg <= cfg_wdata;
        end
    end

    // Offset stage: exact 33-bit differences
    always_comb
    begin
        delta_next.dx  = {s_axis_tdata[31], s_axis_tdata[31:0]}
                       - {s_axis_tdata[95], s_axis_tdata[95:64]};
        delta_next.dy  = {s_axis_tdata[63], s_axis_tdata[63:32]}
                       - {s_axis_tdata[127], s_axis_tdata[127:96]};
        delta_next.yaw = s_axis_tdata[143:128];
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            delta_reg <= delta_next;
        end
    end

    ghde_cordic #(
        .STAGES (CORDIC_STAGES)
    ) u_cordic (
        .clk           (clk),
        .en            (en),
        .delta         (delta_reg),
        .heading_error (cordic_err)
    );

    ghde_isqrt u_isqrt (
        .clk   (clk),
        .en    (en),
        .delta (delta_reg),
        .root  (root)
    );

    // Heading delay to line up with the distance
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            hd_reg[0] <= cordic_err;
        end
    end

    for (genvar j = 1; j < HD; j++)
    begin : g_hdelay
        always_ff @(posedge clk)
        begin
            if (en)
            begin
                hd_reg[j] <= hd_reg[j-1];
            end
        end
    end

    // Output stage: clamp and arrival compare
    assign dist_next = (root > DIST_LIMIT) ? DIST_LIMIT : root;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            err_reg     <= hd_reg[HD-1];
            dist_reg    <= dist_next;
            arrived_reg <= (dist_next <= DIST_W'(tol_reg));
        end
    end

    assign m_axis_tvalid = valid_reg[PIPE_DEPTH-1];
    assign m_axis_tdata  = {6'b000000, arrived_reg, dist_reg, err_reg};

    // Distance never exceeds its range
    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> (dist_reg <= DIST_LIMIT))
        else $error("goal_distance above limit");

    // Zero distance always counts as arrived
    assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && (dist_reg == '0)) |-> arrived_reg)
        else $error("zero distance without arrived");

    // A held result freezes every valid stage
    assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && !m_axis_tready) |=> $stable(valid_reg))
        else $error("pipeline moved during output stall");

endmodule

`default_nettype wire

/* tb/ghde_checker.sv */
`timescale 1ns / 1ps

module ghde_checker #(
    parameter int CORDIC_STAGES = 16
) (
    input  wire logic         clk,
    input  wire logic         rst_n,

    input  wire logic         s_axis_tvalid,
    input  wire logic         s_axis_tready,
    // goal_x[31:0], goal_y[63:32], robot_x[95:64], robot_y[127:96], robot_yaw[143:128]
    input  wire logic [143:0] s_axis_tdata,

    input  wire logic         m_axis_tvalid,
    input  wire logic         m_axis_tready,
    // heading_error[15:0], goal_distance[48:16], arrived[49], zero[55:50]
    input  wire logic [55:0]  m_axis_tdata,

    input  wire logic         cfg_we,
    input  wire logic [31:0]  cfg_wdata,

    output int                mismatches,
    output int                outstanding,
    output int                results_seen,
    output int                arrivals_seen
);
    import ghde_pkg::*;

    typedef struct packed {
        logic signed [AW-1:0] heading_error;
        logic [DIST_W-1:0]    goal_distance;
        logic                 arrived;
    } steer_result_t;

    steer_result_t     pending_steer [$];
    logic [TOL_W-1:0]  tolerance;
    int                errors;
    int                results;
    int                arrivals;

    // Vectoring CORDIC bearing, 32-bit binary angle (2^32 = one turn)
    function automatic logic [31:0] cordic_bearing(input longint dx, input longint dy);
        longint      x;
        longint      y;
        longint      xs;
        longint      ys;
        logic [31:0] z;
        int          i;
        x = dx;
        y = dy;
        z = '0;
        if (dx == 0 && dy == 0)
            return '0;
        // left half plane: pre-rotate by pi
        if (x < 0)
        begin
            x = -x;
            y = -y;
            z = 32'h8000_0000;
        end
        for (i = 0; i < CORDIC_STAGES && i < 32; i++)
        begin
            xs = x >>> i;
            ys = y >>> i;
            if (y >= 0)
            begin
                x = x + ys;
                y = y - xs;
                z = z + ATAN_TURNS[i];
            end
            else
            begin
                x = x - ys;
                y = y + xs;
                z = z - ATAN_TURNS[i];
            end
        end
        return z;
    endfunction

    // Bitwise floor square root of a 66-bit radicand
    function automatic logic [DIST_W-1:0] floor_root(input logic [RAD_W-1:0] rad);
        logic [67:0] rem;
        logic [67:0] trial;
        logic [33:0] root;
        int          i;
        rem  = '0;
        root = '0;
        for (i = 32; i >= 0; i--)
        begin
            rem   = (rem << 2) | 68'(rad[2*i +: 2]);
            trial = 68'({root, 2'b01});
            if (rem >= trial)
            begin
                rem  = rem - trial;
                root = {root[32:0], 1'b1};
            end
            else
                root = root << 1;
        end
        return root[DIST_W-1:0];
    endfunction

    function automatic steer_result_t predict_steer(input logic [143:0] item);
        logic signed [31:0] gx;
        logic signed [31:0] gy;
        logic signed [31:0] rx;
        logic signed [31:0] ry;
        logic [AW-1:0]      yaw;
        longint             dx;
        longint             dy;
        logic [RAD_W-1:0]   ax;
        logic [RAD_W-1:0]   ay;
        logic [DIST_W-1:0]  range_want;
        logic [31:0]        z;
        logic [31:0]        rounded;
        steer_result_t      res;
        gx  = item[31:0];
        gy  = item[63:32];
        rx  = item[95:64];
        ry  = item[127:96];
        yaw = item[143:128];
        dx  = longint'(gx) - longint'(rx);
        dy  = longint'(gy) - longint'(ry);
        ax  = RAD_W'(dx < 0 ? -dx : dx);
        ay  = RAD_W'(dy < 0 ? -dy : dy);
        range_want = floor_root(ax * ax + ay * ay);
        if (range_want > DIST_LIMIT)
            range_want = DIST_LIMIT;
        z       = cordic_bearing(dx, dy);
        rounded = (z + 32'h0000_8000) >> 16;
        res.heading_error = rounded[AW-1:0] - yaw;
        res.goal_distance = range_want;
        res.arrived       = (range_want <= {1'b0, tolerance});
        return res;
    endfunction

    task automatic report_mismatch(input string field, input longint want, input longint got);
        $display("[%0t] %s mismatch on result %0d: expected %0d, got %0d",
                 $time, field, results, want, got);
        errors++;
    endtask

    // Track the register, queue predictions, compare results in order
    always @(posedge clk or negedge rst_n)
    begin
        steer_result_t want;
        if (!rst_n)
        begin
            tolerance = TOL_RESET;
            pending_steer.delete();
            errors   = 0;
            results  = 0;
            arrivals = 0;
        end
        else
        begin
            if (s_axis_tvalid && s_axis_tready)
                pending_steer.push_back(predict_steer(s_axis_tdata));
            if (m_axis_tvalid && m_axis_tready)
            begin
                if (pending_steer.size() == 0)
                begin
                    $display("[%0t] result transfer with no prediction pending", $time);
                    errors++;
                end
                else
                begin
                    want = pending_steer.pop_front();
                    if (m_axis_tdata[15:0] !== want.heading_error)
                        report_mismatch("heading_error", want.heading_error,
                                        $signed(m_axis_tdata[15:0]));
                    if (m_axis_tdata[48:16] !== want.goal_distance)
                        report_mismatch("goal_distance", want.goal_distance,
                                        m_axis_tdata[48:16]);
                    if (m_axis_tdata[49] !== want.arrived)
                        report_mismatch("arrived", want.arrived, m_axis_tdata[49]);
                end
                if (m_axis_tdata[49] === 1'b1)
                    arrivals++;
                results++;
            end
            if (cfg_we)
                tolerance = cfg_wdata;
        end
        mismatches    <= errors;
        outstanding   <= pending_steer.size();
        results_seen  <= results;
        arrivals_seen <= arrivals;
    end

endmodule

/* tb/tb_top.sv */
`timescale 1ns / 1ps

module tb_top;
    import ghde_pkg::*;

    localparam int     PIPE_LATENCY   = 39;
    localparam int     WATCHDOG_LIMIT = 2000;
    localparam int     PHASE_ITEMS    = 76;
    localparam longint FULL_SPAN      = 64'sd4294967295;
    localparam longint COORD_MIN      = -64'sd2147483648;
    localparam longint COORD_MAX      = 64'sd2147483647;

    logic         clk = 1'b0;
    logic         rst_n = 1'b0;
    logic         s_axis_tvalid;
    logic         s_axis_tready;
    // goal_x[31:0], goal_y[63:32], robot_x[95:64], robot_y[127:96], robot_yaw[143:128]
    logic [143:0] s_axis_tdata;
    logic         m_axis_tvalid;
    logic         m_axis_tready = 1'b0;
    // heading_error[15:0], goal_distance[48:16], arrived[49], zero[55:50]
    logic [55:0]  m_axis_tdata;
    logic         cfg_we;
    logic [31:0]  cfg_wdata;

    int           mismatches;
    int           outstanding;
    int           results_seen;
    int           arrivals_seen;

    bit           no_idle = 1'b0;
    int           stall_left;
    int           quiet_cycles;
    int           items_sent;
    int           settings_used;
    logic [31:0]  cur_tol;

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    goal_heading_distance_error dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .cfg_we        (cfg_we),
        .cfg_wdata     (cfg_wdata)
    );

    ghde_checker u_checker (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .cfg_we        (cfg_we),
        .cfg_wdata     (cfg_wdata),
        .mismatches    (mismatches),
        .outstanding   (outstanding),
        .results_seen  (results_seen),
        .arrivals_seen (arrivals_seen)
    );

    // Result sink: random stall bursts, disabled by no_idle
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_axis_tready <= 1'b0;
            stall_left    <= 0;
        end
        else if (stall_left != 0)
        begin
            m_axis_tready <= 1'b0;
            stall_left    <= stall_left - 1;
        end
        else if (!no_idle && $urandom_range(0, 7) == 0)
        begin
            m_axis_tready <= 1'b0;
            stall_left    <= $urandom_range(0, 4);
        end
        else
            m_axis_tready <= 1'b1;
    end

    // Watchdog: too long without any transfer or register write
    always @(posedge clk)
    begin
        if (!rst_n || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)
            || cfg_we)
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("watchdog: no transfer for %0d cycles, %0d results outstanding",
                     WATCHDOG_LIMIT, outstanding);
            $display("TEST FAILED");
            $finish;
        end
    end

    // One input transfer; park drops tvalid after acceptance
    task automatic send_pose(input logic [31:0] gx, input logic [31:0] gy,
                             input logic [31:0] rx, input logic [31:0] ry,
                             input logic [15:0] yaw, input bit park = 1'b0);
        int gap;
        s_axis_tdata  <= {yaw, ry, rx, gy, gx};
        s_axis_tvalid <= 1'b1;
        do
            @(posedge clk);
        while (!s_axis_tready);
        items_sent++;
        gap = (!no_idle && $urandom_range(0, 3) == 0) ? int'($urandom_range(1, 5)) : 0;
        if (park || gap != 0)
            s_axis_tvalid <= 1'b0;
        repeat (gap) @(posedge clk);
    endtask

    // Random robot coordinate such that robot + d stays in range
    function automatic longint base_for(input longint d);
        longint lo;
        longint hi;
        lo = (COORD_MIN - d > COORD_MIN) ? COORD_MIN - d : COORD_MIN;
        hi = (COORD_MAX - d < COORD_MAX) ? COORD_MAX - d : COORD_MAX;
        return lo + longint'({32'd0, $urandom}) % (hi - lo + 1);
    endfunction

    function automatic longint clamp_span(input longint d);
        if (d > FULL_SPAN)
            return FULL_SPAN;
        if (d < -FULL_SPAN)
            return -FULL_SPAN;
        return d;
    endfunction

    task automatic send_offset(input longint dx, input longint dy, input logic [15:0] yaw,
                               input bit park = 1'b0);
        longint cx;
        longint cy;
        longint rx;
        longint ry;
        cx = clamp_span(dx);
        cy = clamp_span(dy);
        rx = base_for(cx);
        ry = base_for(cy);
        send_pose(32'(rx + cx), 32'(ry + cy), 32'(rx), 32'(ry), yaw, park);
    endtask

    function automatic longint rand_mag(input int bits);
        return longint'({32'd0, $urandom}) & ((longint'(1) << bits) - 1);
    endfunction

    function automatic longint rand_sign(input longint v);
        return $urandom_range(0, 1) ? -v : v;
    endfunction

    function automatic logic [15:0] pick_yaw();
        case ($urandom_range(0, 9))
            0:       return 16'h8000;
            1:       return 16'h7FFF;
            2:       return 16'h0000;
            3:       return 16'hFFFF;
            default: return 16'($urandom);
        endcase
    endfunction

    function automatic longint pick_axis_offset();
        case ($urandom_range(0, 5))
            0:       return 0;
            1:       return 1;
            2:       return -1;
            3:       return FULL_SPAN;
            4:       return -FULL_SPAN;
            default: return rand_sign(rand_mag($urandom_range(0, 32)));
        endcase
    endfunction

    function automatic logic [31:0] pick_coord();
        case ($urandom_range(0, 4))
            0:       return 32'h8000_0000;
            1:       return 32'h7FFF_FFFF;
            2:       return 32'h0000_0000;
            3:       return 32'hFFFF_FFFF;
            default: return $urandom;
        endcase
    endfunction

    // One random pose, mostly offsets of chosen size around a random robot
    task automatic send_random(input bit park);
        longint d;
        longint a;
        case ($urandom_range(0, 9))
            0, 1, 2:
                send_pose($urandom, $urandom, $urandom, $urandom, pick_yaw(), park);
            3, 4, 5:
                send_offset(rand_sign(rand_mag($urandom_range(0, 32))),
                            rand_sign(rand_mag($urandom_range(0, 32))), pick_yaw(), park);
            6:
            begin
                // distance right at the arrival tolerance
                d = longint'({32'd0, cur_tol}) + longint'($urandom_range(0, 4)) - 2;
                d = (d < 0) ? 0 : clamp_span(d);
                case ($urandom_range(0, 3))
                    0:       send_offset(d, 0, pick_yaw(), park);
                    1:       send_offset(-d, 0, pick_yaw(), park);
                    2:       send_offset(0, d, pick_yaw(), park);
                    default: send_offset(0, -d, pick_yaw(), park);
                endcase
            end
            7:
                send_offset(pick_axis_offset(), pick_axis_offset(), pick_yaw(), park);
            8:
                send_pose(pick_coord(), pick_coord(), pick_coord(), pick_coord(),
                          pick_yaw(), park);
            default:
            begin
                // near-diagonal offsets
                a = rand_mag($urandom_range(0, 31));
                send_offset(rand_sign(a), rand_sign(a + longint'($urandom_range(0, 2)) - 1),
                            pick_yaw(), park);
            end
        endcase
    endtask

    task automatic run_random(input int count);
        int n;
        for (n = 0; n < count; n++)
            send_random(n == count - 1);
    endtask

    // Wait for every prediction to be matched, then let the pipeline empty
    task automatic drain_results();
        @(posedge clk);
        while (outstanding != 0)
            @(posedge clk);
        repeat (PIPE_LATENCY + 8) @(posedge clk);
    endtask

    task automatic set_tolerance(input logic [31:0] value);
        cfg_we    <= 1'b1;
        cfg_wdata <= value;
        @(posedge clk);
        cfg_we    <= 1'b0;
        cur_tol   = value;
        settings_used++;
    endtask

    initial
    begin
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        cfg_we        = 1'b0;
        cfg_wdata     = '0;
        cur_tol       = TOL_RESET;
        items_sent    = 0;
        settings_used = 1;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        do
            @(posedge clk);
        while (!rst_n);

        // Directed: coincident goal, axes, pi bearing, full-range spans, tolerance edge
        send_offset(0, 0, 16'h0000);
        send_offset(0, 0, 16'h8000);
        send_offset(1000, 0, 16'h0000);
        send_offset(-1000, 0, 16'h0000);
        send_offset(-1, 0, 16'h7FFF);
        send_offset(0, 65536, 16'h0000);
        send_offset(0, -65536, 16'h4000);
        send_pose(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0000, 16'h0000);
        send_pose(32'h8000_0000, 32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 16'h8000);
        send_pose(32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0000, 32'h7FFF_FFFF, 16'h7FFF);
        send_pose(32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000, 16'hFFFF);
        send_offset(-FULL_SPAN, 0, 16'h0000);
        send_offset(0, FULL_SPAN, 16'h0001);
        send_offset(6554, 0, 16'h2000);
        send_offset(0, -6555, 16'hC000);
        send_offset(-6553, 0, 16'h0000);
        send_offset(4634, 4634, 16'h0000);
        send_pose(32'h0, 32'h0, 32'h0, 32'h0, 16'h0000);
        send_pose(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 16'hFFFF);
        send_offset(1, -1, 16'h8000);
        send_offset(-1, -1, 16'h7FFF, 1'b1);
        drain_results();

        // Random phases over several tolerance settings, extremes included
        set_tolerance(32'h0000_0000);
        run_random(PHASE_ITEMS);
        drain_results();
        set_tolerance(32'hFFFF_FFFF);
        run_random(PHASE_ITEMS);
        drain_results();
        set_tolerance($urandom_range(1, 1 << 20));
        run_random(PHASE_ITEMS);
        drain_results();
        set_tolerance($urandom);
        run_random(PHASE_ITEMS);
        drain_results();
        // closing phase at full rate, no idling on either side
        set_tolerance(TOL_RESET);
        no_idle = 1'b1;
        run_random(PHASE_ITEMS);
        drain_results();

        $display("Sent %0d pose items (directed extremes, axis and pi-bearing cases, random)",
                 items_sent);
        $display("under %0d tolerance settings; %0d results checked, %0d flagged arrived.",
                 settings_used, results_seen, arrivals_seen);
        if (mismatches == 0 && outstanding == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule
